// File: design/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);
// Signal must not be unknown outside reset.
`define CHK_KNOWN(label, clk, rst_n, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

// File: design/spu_pkg.sv
// ----------------------------------------------------------------------------
// spu_pkg
// Types and constants of the particle swarm update block.
// ----------------------------------------------------------------------------
package spu_pkg;
	// Binary point of the coordinates; the arithmetic does not depend on it.
	localparam int FracBits = 16;
	localparam int QueueDepth = 2;
	localparam logic [31:0] LcgMul = 32'd1103515245;
	localparam logic [31:0] LcgAdd = 32'd12345;
	// Two generator steps folded into one: s2 = LcgMul2 * s + LcgAdd2.
	localparam logic [31:0] LcgMul2 = 32'(64'(LcgMul) * 64'(LcgMul));
	localparam logic [31:0] LcgAdd2 = 32'(64'(LcgMul) * 64'(LcgAdd) + 64'(LcgAdd));

	typedef enum logic [2:0] {
		REG_INERTIA_START = 3'd0,
		REG_DECAY         = 3'd1,
		REG_PERSONAL_GAIN = 3'd2,
		REG_GLOBAL_GAIN   = 3'd3,
		REG_VEL_LIMIT     = 3'd4,
		REG_RANDOM_SEED   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] personal_best;
		logic signed [31:0] global_best;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic               last_of_sweep;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_position;
		logic signed [31:0] new_velocity;
		logic               hit_bound;
	} out_item_t;

	// Classified job handed from the front to the back part.
	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [32:0] diff_p;
		logic signed [32:0] diff_g;
		logic signed [32:0] span;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic               last_of_sweep;
		logic [14:0]        r1;
		logic [14:0]        r2;
	} job_t;

	typedef struct packed {
		logic [15:0] decay;
		logic [15:0] personal_gain;
		logic [15:0] global_gain;
		logic [15:0] vel_limit;
	} cfg_t;
endpackage

// File: design/spu_front.sv
// ----------------------------------------------------------------------------
// spu_front
// Accepts input beats, steps the generator twice and forms exact differences.
// ----------------------------------------------------------------------------
module spu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spu_pkg::in_item_t in_data,
	input  logic              seed_load,
	input  logic [31:0]       seed_value,
	output logic              job_valid,
	input  logic              job_ready,
	output spu_pkg::job_t     job_data
);
	import spu_pkg::*;

	logic [31:0] rnd_q;
	logic [31:0] s1, s2;
	logic        take;

	// Both generator steps are formed in parallel from the stored state;
	// each is one 32x32 low-half product.
	assign s1 = rnd_q * LcgMul + LcgAdd;
	assign s2 = rnd_q * LcgMul2 + LcgAdd2;
	assign in_ready = job_ready;
	assign take = in_valid && in_ready;
	assign job_valid = in_valid;

	always_comb begin
		job_data.position = in_data.position;
		job_data.velocity = in_data.velocity;
		job_data.diff_p = 33'(in_data.personal_best) - 33'(in_data.position);
		job_data.diff_g = 33'(in_data.global_best) - 33'(in_data.position);
		job_data.span = 33'(in_data.upper_bound) - 33'(in_data.lower_bound);
		job_data.lower_bound = in_data.lower_bound;
		job_data.upper_bound = in_data.upper_bound;
		job_data.last_of_sweep = in_data.last_of_sweep;
		job_data.r1 = s1[30:16];
		job_data.r2 = s2[30:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= 32'd1;
		end else if (seed_load) begin
			rnd_q <= seed_value;
		end else if (take) begin
			rnd_q <= s2;
		end
	end
endmodule

// File: design/spu_queue.sv
// ----------------------------------------------------------------------------
// spu_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module spu_queue #(
	parameter int DEPTH = spu_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  spu_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output spu_pkg::job_t rd_data
);
	import spu_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// File: design/spu_back.sv
// ----------------------------------------------------------------------------
// spu_back
// Sequencer sharing one signed multiplier over the velocity update steps.
// ----------------------------------------------------------------------------
module spu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  spu_pkg::cfg_t      cfg,
	input  logic               w_load,
	input  logic [15:0]        w_value,
	input  logic               job_valid,
	output logic               job_ready,
	input  spu_pkg::job_t      job_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spu_pkg::out_item_t out_data
);
	import spu_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_INER  = 8'b00000010,
		ST_PT    = 8'b00000100,
		ST_PR    = 8'b00001000,
		ST_GT    = 8'b00010000,
		ST_GR    = 8'b00100000,
		ST_LIM   = 8'b01000000,
		ST_FIN   = 8'b10000000
	} st_t;

	st_t                state_q;
	job_t               job_q;
	logic [15:0]        w_q;
	logic signed [36:0] acc_q;   // velocity sum
	logic signed [35:0] t_q;     // pull before random scaling
	logic signed [33:0] lim_q;
	logic signed [35:0] ma;
	logic signed [17:0] mb;
	logic signed [53:0] prod;
	logic signed [36:0] v, nv;
	logic signed [33:0] p;
	logic signed [31:0] pos_o, vel_o;
	logic               hit;
	logic               out_full_q;
	logic               fin_go;

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = out_full_q;
	assign prod = ma * mb;
	// The final step completes once the output register is free or drains now.
	assign fin_go = (state_q == ST_FIN) && (!out_full_q || out_ready);

	always_comb begin
		unique case (state_q)
			ST_INER: begin ma = 36'(job_q.velocity); mb = 18'($signed({1'b0, w_q})); end
			ST_PT:   begin ma = 36'(job_q.diff_p); mb = 18'($signed({1'b0, cfg.personal_gain})); end
			ST_PR:   begin ma = t_q; mb = 18'($signed({1'b0, job_q.r1})); end
			ST_GT:   begin ma = 36'(job_q.diff_g); mb = 18'($signed({1'b0, cfg.global_gain})); end
			ST_GR:   begin ma = t_q; mb = 18'($signed({1'b0, job_q.r2})); end
			ST_LIM:  begin ma = 36'(job_q.span); mb = 18'($signed({1'b0, cfg.vel_limit})); end
			default: begin ma = 36'($signed({1'b0, w_q})); mb = 18'($signed({1'b0, cfg.decay})); end
		endcase
	end

	// Clamp, move, clip and saturate in the final step.
	always_comb begin
		v = acc_q;
		if (v < -37'(lim_q)) begin
			v = -37'(lim_q);
		end else if (v > 37'(lim_q)) begin
			v = 37'(lim_q);
		end
		nv = v;
		hit = 1'b0;
		p = 34'(job_q.position) + 34'(v);
		if (p < 34'(job_q.lower_bound)) begin
			p = 34'(job_q.lower_bound);
			nv = -v;
			hit = 1'b1;
		end else if (p > 34'(job_q.upper_bound)) begin
			p = 34'(job_q.upper_bound);
			nv = -v;
			hit = 1'b1;
		end
		pos_o = p[31:0];
		if (nv > 37'sd2147483647) begin
			vel_o = 32'sh7fffffff;
		end else if (nv < -37'sd2147483648) begin
			vel_o = 32'sh80000000;
		end else begin
			vel_o = nv[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_q <= job_data;
		end
		unique case (state_q)
			ST_INER: acc_q <= 37'(prod >>> 14);
			ST_PT:   t_q <= 36'(prod >>> 14);
			ST_PR:   acc_q <= acc_q + 37'(prod >>> 15);
			ST_GT:   t_q <= 36'(prod >>> 14);
			ST_GR:   acc_q <= acc_q + 37'(prod >>> 15);
			ST_LIM:  lim_q <= 34'(prod >>> 16);
			default: ;
		endcase
		if (fin_go) begin
			out_data.new_position <= pos_o;
			out_data.new_velocity <= vel_o;
			out_data.hit_bound <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q <= 16'd11469;
			out_full_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_full_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_full_q <= 1'b0;
			end
			if (w_load) begin
				w_q <= w_value;
			end else if (fin_go && job_q.last_of_sweep) begin
				w_q <= prod[31:16];
			end
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= ST_INER;
				ST_INER: state_q <= ST_PT;
				ST_PT:   state_q <= ST_PR;
				ST_PR:   state_q <= ST_GT;
				ST_GT:   state_q <= ST_GR;
				ST_GR:   state_q <= ST_LIM;
				ST_LIM:  state_q <= ST_FIN;
				// Wait until the output register is free.
				ST_FIN:  if (fin_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: design/swarm_particle_update.sv
// ----------------------------------------------------------------------------
// swarm_particle_update
// Particle swarm velocity and position update, one coordinate per beat.
// ----------------------------------------------------------------------------
// Usage: an input beat carries one coordinate of one particle (position,
// velocity, both bests and the bounds). The front part steps the random
// generator twice and forms exact differences; a two-entry queue hands the
// job to the back part. The back part runs the inertia and pull products
// and the velocity limit through one shared multiplier, one product per
// cycle, then clamps, moves and clips in a final step. With the block empty
// a result beat passes through the queue, the six product steps and the
// final step into the output register. The back part takes a new job only
// from its idle state, after the final step of the last job has completed.
// The result waits in an output register; while the receiver stalls
// the block holds one finished result, one item at the final step and two
// in the queue before in_ready drops. Configuration writes (index, data) are
// taken at once and are meant for an idle block. Reset loads the documented
// register defaults and empties the queue and the output register.
// ----------------------------------------------------------------------------
module swarm_particle_update #(
	parameter int QUEUE_DEPTH = spu_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spu_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spu_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import spu_pkg::*;

	cfg_t  cfg_q;
	job_t  fj, qj;
	logic  fv, fr, qv, qr;
	logic  wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay <= 16'd64881;
			cfg_q.personal_gain <= 16'd24576;
			cfg_q.global_gain <= 16'd24576;
			cfg_q.vel_limit <= 16'd13107;
		end else if (wr) begin
			unique case (cfg_index)
				REG_DECAY:         cfg_q.decay <= cfg_data[15:0];
				REG_PERSONAL_GAIN: cfg_q.personal_gain <= cfg_data[15:0];
				REG_GLOBAL_GAIN:   cfg_q.global_gain <= cfg_data[15:0];
				REG_VEL_LIMIT:     cfg_q.vel_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	spu_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.seed_load(wr && cfg_index == REG_RANDOM_SEED), .seed_value(cfg_data),
		.job_valid(fv), .job_ready(fr), .job_data(fj)
	);

	spu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj)
	);

	spu_back u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.w_load(wr && cfg_index == REG_INERTIA_START), .w_value(cfg_data[15:0]),
		.job_valid(qv), .job_ready(qr), .job_data(qj),
		.out_valid, .out_ready, .out_data
	);
endmodule

// File: design/spu_checker.sv
// ----------------------------------------------------------------------------
// spu_port_props
// Port-level checks of the particle swarm update block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module spu_port_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input spu_pkg::out_item_t out_data,
	input logic               cfg_ready
);
	`CHK_IMPLY(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while stalled")
	`CHK_KNOWN(a_out_known, clk, arst_n, out_valid, "out_valid unknown")
	`CHK_IMPLY(a_data_known, clk, arst_n, out_valid |-> !$isunknown(out_data), "result beat carries unknown bits")
	`CHK_KNOWN(a_in_ready_known, clk, arst_n, in_ready, "in_ready unknown")
	`CHK_IMPLY(a_cfg_ready, clk, arst_n, cfg_ready, "config port not ready")
endmodule

bind swarm_particle_update spu_port_props u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_data, .cfg_ready
);
